>>> hdl/sslv2_pkg.sv
package sslv2_pkg;

  // Client random is always this long; the challenge is right-aligned in it.
  localparam int unsigned RandomBytes = 32;
  localparam int unsigned RandIdxW    = $clog2(RandomBytes);
  localparam int unsigned ChallMin    = 16;
  localparam int unsigned ChallMax    = RandomBytes;
  localparam int unsigned PadW        = RandIdxW + 1;

  // Final status codes.
  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StBadType = 2'd1;
  localparam logic [1:0] StBadData = 2'd2;
  localparam logic [1:0] StShort   = 2'd3;

  // Result kinds.
  localparam logic [1:0] KindSpec = 2'd0;
  localparam logic [1:0] KindRand = 2'd1;
  localparam logic [1:0] KindStat = 2'd2;

  // Work handed from the parser to the result sequencer for one input item.
  typedef struct packed {
    logic                has_spec;
    logic [23:0]         spec;
    logic                has_final;
    logic [1:0]          status;
    logic [15:0]         version;
    logic [PadW-1:0]     pad;
  } ev_t;

  // Residue modulo 3 of a 4-bit value.
  function automatic logic [1:0] mod3_nib(logic [3:0] v);
    logic [1:0] r;
    case (v)
      4'd0, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15: r = 2'd0;
      4'd1, 4'd4, 4'd7, 4'd10, 4'd13:       r = 2'd1;
      default:                             r = 2'd2;
    endcase
    return r;
  endfunction

  // Residue modulo 3 of a byte: 4 is 1 mod 3, so the base-4 digits just add.
  function automatic logic [1:0] mod3_byte(logic [7:0] v);
    logic [3:0] s;
    s = {2'b00, v[1:0]} + {2'b00, v[3:2]} + {2'b00, v[5:4]} + {2'b00, v[7:6]};
    return mod3_nib(s);
  endfunction

endpackage

>>> hdl/sslv2_if.sv
// Byte stream into the parser.
interface sslv2_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink (input valid, data_byte, last_byte, output ready);
endinterface

// Result items out of the parser.
interface sslv2_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [23:0] cipher_spec;
  logic [7:0]  random_byte;
  logic [4:0]  random_index;
  logic [1:0]  status;
  logic [15:0] client_version;
  logic        last_result;

  modport source (output valid, kind, cipher_spec, random_byte, random_index, status,
                  client_version, last_result, input ready);
  modport sink (input valid, kind, cipher_spec, random_byte, random_index, status,
                client_version, last_result, output ready);
endinterface

>>> hdl/sslv2_ram.sv
module sslv2_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/sslv2_parse.sv
module sslv2_parse (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                accept_i,
  input  logic [7:0]                          data_byte_i,
  input  logic                                last_byte_i,
  output logic                                ev_valid_o,
  output sslv2_pkg::ev_t                      ev_o,
  output logic                                we_o,
  output logic [sslv2_pkg::RandIdxW-1:0]      waddr_o,
  output logic [7:0]                          wdata_o
);
  import sslv2_pkg::*;

  localparam logic [3:0] PhLenHi = 4'd0;
  localparam logic [3:0] PhLenLo = 4'd1;
  localparam logic [3:0] PhType  = 4'd2;
  localparam logic [3:0] PhVerHi = 4'd3;
  localparam logic [3:0] PhVerLo = 4'd4;
  localparam logic [3:0] PhCsHi  = 4'd5;
  localparam logic [3:0] PhCsLo  = 4'd6;
  localparam logic [3:0] PhSidHi = 4'd7;
  localparam logic [3:0] PhSidLo = 4'd8;
  localparam logic [3:0] PhChHi  = 4'd9;
  localparam logic [3:0] PhChLo  = 4'd10;
  localparam logic [3:0] PhSpecs = 4'd11;
  localparam logic [3:0] PhChall = 4'd12;
  localparam logic [3:0] PhDone  = 4'd13;
  localparam logic [3:0] PhError = 4'd14;

  logic [3:0]  phase_q, phase_d;
  logic [15:0] bcnt_q, bcnt_d;
  logic [14:0] rec_q, rec_d;
  logic [15:0] ver_q, ver_d;
  logic [15:0] srem_q, srem_d;
  logic [15:0] sid_q, sid_d;
  logic [15:0] chl_q, chl_d;
  logic [5:0]  ccnt_q, ccnt_d;
  logic [23:0] acc_q, acc_d;
  logic [1:0]  err_q, err_d;
  logic [1:0]  hi3_q, hi3_d;
  logic [1:0]  cs3_q, cs3_d;
  logic [1:0]  spos_q, spos_d;
  logic        spec_fire;
  logic        specs_end;
  logic [1:0]  fin_status;

  // Next parse state for the byte on the input.
  always_comb begin
    phase_d   = phase_q;
    rec_d     = rec_q;
    ver_d     = ver_q;
    srem_d    = srem_q;
    sid_d     = sid_q;
    chl_d     = chl_q;
    ccnt_d    = ccnt_q;
    acc_d     = acc_q;
    err_d     = err_q;
    hi3_d     = hi3_q;
    cs3_d     = cs3_q;
    spos_d    = spos_q;
    spec_fire = 1'b0;
    specs_end = 1'b0;
    we_o      = 1'b0;
    bcnt_d    = (bcnt_q != '1) ? bcnt_q + 16'd1 : bcnt_q;

    case (phase_q)
      PhLenHi: begin
        rec_d   = {data_byte_i[6:0], 8'h00};
        phase_d = PhLenLo;
      end
      PhLenLo: begin
        rec_d   = {rec_q[14:8], data_byte_i};
        phase_d = PhType;
      end
      PhType: begin
        if (data_byte_i != 8'd1) begin
          err_d   = StBadType;
          phase_d = PhError;
        end else begin
          phase_d = PhVerHi;
        end
      end
      PhVerHi: begin
        ver_d   = {data_byte_i, 8'h00};
        phase_d = PhVerLo;
      end
      PhVerLo: begin
        ver_d = {ver_q[15:8], data_byte_i};
        if (ver_d <= 16'd2) begin
          err_d   = StBadData;
          phase_d = PhError;
        end else begin
          phase_d = PhCsHi;
        end
      end
      PhCsHi: begin
        srem_d  = {data_byte_i, 8'h00};
        hi3_d   = mod3_byte(data_byte_i);
        phase_d = PhCsLo;
      end
      PhCsLo: begin
        // 256 is 1 mod 3, so the residue of the length is that of the byte sum.
        srem_d  = {srem_q[15:8], data_byte_i};
        cs3_d   = mod3_nib({2'b00, hi3_q} + {2'b00, mod3_byte(data_byte_i)});
        phase_d = PhSidHi;
      end
      PhSidHi: begin
        sid_d   = {data_byte_i, 8'h00};
        phase_d = PhSidLo;
      end
      PhSidLo: begin
        sid_d   = {sid_q[15:8], data_byte_i};
        phase_d = PhChHi;
      end
      PhChHi: begin
        chl_d   = {data_byte_i, 8'h00};
        phase_d = PhChLo;
      end
      PhChLo: begin
        chl_d = {chl_q[15:8], data_byte_i};
        if (cs3_q != 2'd0) begin
          err_d   = StBadData;
          phase_d = PhError;
        end else if (srem_q == 16'd0) begin
          specs_end = 1'b1;
        end else begin
          spos_d  = 2'd0;
          phase_d = PhSpecs;
        end
      end
      PhSpecs: begin
        // Every third byte closes a cipher spec.
        acc_d  = {acc_q[15:0], data_byte_i};
        srem_d = srem_q - 16'd1;
        if (spos_q == 2'd2) begin
          spos_d    = 2'd0;
          spec_fire = 1'b1;
          specs_end = (srem_d == 16'd0);
        end else begin
          spos_d = spos_q + 2'd1;
        end
      end
      PhChall: begin
        we_o   = 1'b1;
        ccnt_d = ccnt_q + 6'd1;
        if ({10'd0, ccnt_d} >= chl_q) begin
          phase_d = PhDone;
        end
      end
      default: begin
      end
    endcase

    // Session id and challenge checks once all cipher specs are in.
    if (specs_end) begin
      if (sid_q != 16'd0 || chl_d < 16'(ChallMin) || chl_d > 16'(ChallMax)) begin
        err_d   = StBadData;
        phase_d = PhError;
      end else begin
        ccnt_d  = 6'd0;
        phase_d = PhChall;
      end
    end
  end

  // Status of the segment, in priority order.
  always_comb begin
    if (bcnt_d < 16'd4 || (bcnt_d - 16'd2) != {1'b0, rec_d}) begin
      fin_status = StBadType;
    end else if (err_d != StOk) begin
      fin_status = err_d;
    end else if (phase_d != PhDone) begin
      fin_status = StShort;
    end else begin
      fin_status = StOk;
    end
  end

  assign waddr_o = ccnt_q[RandIdxW-1:0];
  assign wdata_o = data_byte_i;

  assign ev_valid_o      = spec_fire | last_byte_i;
  assign ev_o.has_spec   = spec_fire;
  assign ev_o.spec       = acc_d;
  assign ev_o.has_final  = last_byte_i;
  assign ev_o.status     = fin_status;
  assign ev_o.version    = ver_d;
  assign ev_o.pad        = PadW'(RandomBytes) - chl_d[PadW-1:0];

  // Parse state; the last byte of a segment starts the next one clean.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhLenHi;
      bcnt_q  <= '0;
      rec_q   <= '0;
      ver_q   <= '0;
      srem_q  <= '0;
      sid_q   <= '0;
      chl_q   <= '0;
      ccnt_q  <= '0;
      acc_q   <= '0;
      err_q   <= StOk;
      hi3_q   <= '0;
      cs3_q   <= '0;
      spos_q  <= '0;
    end else if (accept_i) begin
      if (last_byte_i) begin
        phase_q <= PhLenHi;
        bcnt_q  <= '0;
        rec_q   <= '0;
        ver_q   <= '0;
        srem_q  <= '0;
        sid_q   <= '0;
        chl_q   <= '0;
        ccnt_q  <= '0;
        acc_q   <= '0;
        err_q   <= StOk;
        hi3_q   <= '0;
        cs3_q   <= '0;
        spos_q  <= '0;
      end else begin
        phase_q <= phase_d;
        bcnt_q  <= bcnt_d;
        rec_q   <= rec_d;
        ver_q   <= ver_d;
        srem_q  <= srem_d;
        sid_q   <= sid_d;
        chl_q   <= chl_d;
        ccnt_q  <= ccnt_d;
        acc_q   <= acc_d;
        err_q   <= err_d;
        hi3_q   <= hi3_d;
        cs3_q   <= cs3_d;
        spos_q  <= spos_d;
      end
    end
  end

endmodule

>>> hdl/sslv2_client_hello_parser.sv
// Parses an SSLv2-compatible client hello one byte per cycle. Each complete
// cipher spec comes out as a result; the byte marked last yields a status
// (and version), preceded on success by the 32 client-random bytes with the
// challenge right-aligned. The header fields live in registers, the challenge
// in a 32-entry RAM with a registered read. Input takes one byte per cycle
// while results drain and no earlier byte still has results to give; a byte
// that makes more than one result (a spec plus a status) holds input until
// its last result is loaded, as does a successful hello, whose status follows
// its random bytes, those in the challenge read from the RAM port. An output
// register separates the result side from the parser, so input keeps flowing
// while a finished result waits to be taken, until a new result must be held.
module sslv2_client_hello_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  sslv2_in_if.sink    in_i,
  sslv2_out_if.source out_o
);
  import sslv2_pkg::*;

  localparam logic [1:0] EmSpec = 2'd0;
  localparam logic [1:0] EmRand = 2'd1;
  localparam logic [1:0] EmStat = 2'd2;

  logic                in_acc;
  logic                pev_valid;
  ev_t                 pev;
  logic                ram_we;
  logic [RandIdxW-1:0] ram_waddr;
  logic [7:0]          ram_wdata;
  logic                ram_re;
  logic [RandIdxW-1:0] ram_raddr;
  logic [7:0]          ram_rdata;

  logic                ev_valid_q;
  ev_t                 ev_q;
  logic [1:0]          em_q;
  logic [RandIdxW-1:0] idx_q;

  logic                out_valid_q;
  logic [1:0]          kind_q;
  logic [23:0]         spec_q;
  logic [7:0]          byte_q;
  logic                fresh_q;
  logic [RandIdxW-1:0] ridx_q;
  logic [1:0]          status_q;
  logic [15:0]         ver_q;
  logic                last_q;

  logic                out_load;
  logic                iss_last;
  logic [1:0]          iss_kind;
  logic [1:0]          em_nxt;
  logic                iss_rd;
  logic                ev_done;
  logic [1:0]          em_init;

  sslv2_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_acc),
    .data_byte_i (in_i.data_byte),
    .last_byte_i (in_i.last_byte),
    .ev_valid_o  (pev_valid),
    .ev_o        (pev),
    .we_o        (ram_we),
    .waddr_o     (ram_waddr),
    .wdata_o     (ram_wdata)
  );

  sslv2_ram #(
    .Width (8),
    .Depth (RandomBytes)
  ) u_chall_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we & in_acc),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Which result the held item produces next.
  always_comb begin
    iss_kind = KindStat;
    iss_last = 1'b1;
    iss_rd   = 1'b0;
    em_nxt   = EmStat;
    case (em_q)
      EmSpec: begin
        iss_kind = KindSpec;
        iss_last = !ev_q.has_final;
        em_nxt   = (ev_q.status == StOk) ? EmRand : EmStat;
      end
      EmRand: begin
        iss_kind = KindRand;
        iss_last = 1'b0;
        iss_rd   = ({1'b0, idx_q} >= ev_q.pad);
        em_nxt   = (idx_q == RandIdxW'(RandomBytes - 1)) ? EmStat : EmRand;
      end
      EmStat: begin
        iss_kind = KindStat;
        iss_last = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign out_load  = ev_valid_q && (!out_valid_q || out_o.ready);
  assign ev_done   = out_load && iss_last;
  assign in_i.ready = !ev_valid_q || ev_done;
  assign in_acc    = in_i.valid && in_i.ready;
  assign ram_re    = out_load && (em_q == EmRand) && iss_rd;
  assign ram_raddr = idx_q - ev_q.pad[RandIdxW-1:0];
  assign em_init   = pev.has_spec ? EmSpec : ((pev.status == StOk) ? EmRand : EmStat);

  // Held item and its position in the result sequence.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_valid_q <= 1'b0;
      em_q       <= EmSpec;
      idx_q      <= '0;
    end else begin
      if (in_acc && pev_valid) begin
        ev_valid_q <= 1'b1;
        em_q       <= em_init;
        idx_q      <= '0;
      end else if (ev_done) begin
        ev_valid_q <= 1'b0;
      end else if (out_load) begin
        em_q  <= em_nxt;
        idx_q <= (em_q == EmRand) ? idx_q + RandIdxW'(1) : '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && pev_valid) begin
      ev_q <= pev;
    end
  end

  // Output register; a random byte read this cycle is captured if it stalls.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      fresh_q     <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
        fresh_q     <= ram_re;
      end else begin
        if (out_o.ready) begin
          out_valid_q <= 1'b0;
        end
        fresh_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      kind_q   <= iss_kind;
      spec_q   <= (iss_kind == KindSpec) ? ev_q.spec : 24'd0;
      byte_q   <= 8'd0;
      ridx_q   <= (iss_kind == KindRand) ? idx_q : '0;
      status_q <= (iss_kind == KindStat) ? ev_q.status : StOk;
      ver_q    <= (iss_kind == KindStat) ? ev_q.version : 16'd0;
      last_q   <= iss_last;
    end else if (fresh_q) begin
      byte_q <= ram_rdata;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.kind           = kind_q;
  assign out_o.cipher_spec    = spec_q;
  assign out_o.random_byte    = fresh_q ? ram_rdata : byte_q;
  assign out_o.random_index   = ridx_q;
  assign out_o.status         = status_q;
  assign out_o.client_version = ver_q;
  assign out_o.last_result    = last_q;

endmodule
